// ----- rtl/key_to_escape_sequence_encoder_assert.svh -----
// Assertion macros shared by the encoder RTL. They sample on clk_i and are
// disabled while rst_ni is low.
`ifndef KEY_TO_ESCAPE_SEQUENCE_ENCODER_ASSERT_SVH
`define KEY_TO_ESCAPE_SEQUENCE_ENCODER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define KESENC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// An implication checked within the same clock edge.
`define KESENC_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/kesenc_pkg.sv -----
`default_nettype none

package kesenc_pkg;

  // Longest sequence a key can produce, and the queue depth between front and back.
  localparam int unsigned SeqMax = 7;
  localparam int unsigned QDepth = 2;

  localparam logic [7:0] EscByte  = 8'h1B;
  localparam logic [7:0] DelByte  = 8'h7F;
  localparam logic [7:0] BsByte   = 8'h08;

  // Configuration register indexes.
  localparam logic [2:0] CFG_APP_CURSOR = 3'd0;
  localparam logic [2:0] CFG_HOME_END   = 3'd1;
  localparam logic [2:0] CFG_BS_DELETE  = 3'd2;
  localparam logic [2:0] CFG_FN_STYLE   = 3'd3;
  localparam logic [2:0] CFG_APP_KEYPAD = 3'd4;

  // Home/end styles.
  localparam logic [1:0] HOME_END_TILDE = 2'd1;
  localparam logic [1:0] HOME_END_RXVT  = 2'd2;

  // Virtual-key codes with a translation of their own.
  localparam logic [7:0] VkBack     = 8'h08;
  localparam logic [7:0] VkPageUp   = 8'h21;
  localparam logic [7:0] VkPageDown = 8'h22;
  localparam logic [7:0] VkEnd      = 8'h23;
  localparam logic [7:0] VkHome     = 8'h24;
  localparam logic [7:0] VkLeft     = 8'h25;
  localparam logic [7:0] VkUp       = 8'h26;
  localparam logic [7:0] VkRight    = 8'h27;
  localparam logic [7:0] VkDown     = 8'h28;
  localparam logic [7:0] VkInsert   = 8'h2D;
  localparam logic [7:0] VkDelete   = 8'h2E;
  localparam logic [7:0] VkNum0     = 8'h60;
  localparam logic [7:0] VkNum9     = 8'h69;
  localparam logic [7:0] VkMultiply = 8'h6A;
  localparam logic [7:0] VkAdd      = 8'h6B;
  localparam logic [7:0] VkSubtract = 8'h6D;
  localparam logic [7:0] VkDecimal  = 8'h6E;
  localparam logic [7:0] VkDivide   = 8'h6F;
  localparam logic [7:0] VkF1       = 8'h70;
  localparam logic [7:0] VkF12      = 8'h7B;

  typedef enum logic [1:0] {
    FN_XTERM = 2'd0,
    FN_LINUX = 2'd1,
    FN_VT100 = 2'd2,
    FN_SCO   = 2'd3
  } fn_style_e;

  typedef struct packed {
    logic       app_cursor;
    logic [1:0] home_end;
    logic       bs_delete;
    fn_style_e  fn_style;
    logic       app_keypad;
  } cfg_t;

  // One translated key: its bytes in order and how many are used.
  typedef struct packed {
    logic [SeqMax-1:0][7:0] bytes;
    logic [2:0]             len;
  } seq_t;

  // Append one byte; anything beyond the buffer is dropped.
  function automatic seq_t seq_put(seq_t s, logic [7:0] b);
    seq_t r;
    r = s;
    if (r.len < 3'(SeqMax)) begin
      r.bytes[r.len] = b;
      r.len = r.len + 3'd1;
    end
    return r;
  endfunction

  // Append a value below 30 in decimal, with no leading zero.
  function automatic seq_t seq_dec(seq_t s, logic [4:0] v);
    seq_t r;
    logic [4:0] ones;
    r = s;
    ones = v;
    if (v >= 5'd20) begin
      r = seq_put(r, 8'h32);
      ones = v - 5'd20;
    end else if (v >= 5'd10) begin
      r = seq_put(r, 8'h31);
      ones = v - 5'd10;
    end
    r = seq_put(r, 8'h30 + {3'b000, ones});
    return r;
  endfunction

  // Cursor-style sequence: CSI 1;m x when modified, else SS3 x or CSI x.
  function automatic seq_t seq_cursor(seq_t s, logic [7:0] letter, logic [3:0] mp,
                                      logic app);
    seq_t r;
    r = seq_put(s, EscByte);
    if (mp != 4'd1) begin
      r = seq_put(r, 8'h5B);
      r = seq_put(r, 8'h31);
      r = seq_put(r, 8'h3B);
      r = seq_dec(r, {1'b0, mp});
    end else if (app) begin
      r = seq_put(r, 8'h4F);
    end else begin
      r = seq_put(r, 8'h5B);
    end
    r = seq_put(r, letter);
    return r;
  endfunction

  // Tilde sequence: CSI n ~ or CSI n;m ~.
  function automatic seq_t seq_tilde(seq_t s, logic [4:0] num, logic [3:0] mp);
    seq_t r;
    r = seq_put(s, EscByte);
    r = seq_put(r, 8'h5B);
    r = seq_dec(r, num);
    if (mp != 4'd1) begin
      r = seq_put(r, 8'h3B);
      r = seq_dec(r, {1'b0, mp});
    end
    r = seq_put(r, 8'h7E);
    return r;
  endfunction

  function automatic seq_t seq_ss3(seq_t s, logic [7:0] letter);
    seq_t r;
    r = seq_put(s, EscByte);
    r = seq_put(r, 8'h4F);
    r = seq_put(r, letter);
    return r;
  endfunction

  // Tilde code of function key n (1 to 12).
  function automatic logic [4:0] fn_tilde_code(logic [3:0] n);
    logic [4:0] c;
    unique case (n)
      4'd1:    c = 5'd11;
      4'd2:    c = 5'd12;
      4'd3:    c = 5'd13;
      4'd4:    c = 5'd14;
      4'd5:    c = 5'd15;
      4'd6:    c = 5'd17;
      4'd7:    c = 5'd18;
      4'd8:    c = 5'd19;
      4'd9:    c = 5'd20;
      4'd10:   c = 5'd21;
      4'd11:   c = 5'd23;
      4'd12:   c = 5'd24;
      default: c = 5'd0;
    endcase
    return c;
  endfunction

  // Function key n (1 to 12) in the configured flavor.
  function automatic seq_t seq_fn(seq_t s, fn_style_e style, logic [3:0] n,
                                  logic [3:0] mp, logic shift, logic ctrl);
    seq_t r;
    logic [7:0] base;
    r = s;
    base = 8'h4C + {4'b0000, n};
    unique case (style)
      FN_LINUX: begin
        if (n <= 4'd5) begin
          r = seq_put(r, EscByte);
          r = seq_put(r, 8'h5B);
          r = seq_put(r, 8'h5B);
          r = seq_put(r, 8'h40 + {4'b0000, n});
        end else begin
          r = seq_tilde(r, fn_tilde_code(n), mp);
        end
      end
      FN_VT100: begin
        r = seq_put(r, EscByte);
        r = seq_put(r, 8'h4F);
        r = seq_put(r, 8'h4F + {4'b0000, n});
      end
      FN_SCO: begin
        if (shift) begin
          base = base + 8'd12;
        end
        if (ctrl) begin
          base = base + 8'd24;
        end
        if (base > 8'h7A) begin
          base = 8'h7A;
        end
        r = seq_put(r, EscByte);
        r = seq_put(r, 8'h5B);
        r = seq_put(r, base);
      end
      default: begin
        if (n <= 4'd4) begin
          r = seq_cursor(r, 8'h4F + {4'b0000, n}, mp, 1'b1);
        end else begin
          r = seq_tilde(r, fn_tilde_code(n), mp);
        end
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/kesenc_front.sv -----
`default_nettype none

module kesenc_front import kesenc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_index_i,
  input  wire logic [1:0] cfg_wdata_i,
  input  wire logic [7:0] key_code_i,
  input  wire logic       shift_held_i,
  input  wire logic       alt_held_i,
  input  wire logic       ctrl_held_i,
  output seq_t            seq_o
);

  cfg_t cfg_q, cfg_d;

  // Configuration registers, written one at a time by index.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_APP_CURSOR: cfg_d.app_cursor = cfg_wdata_i[0];
        CFG_HOME_END:   cfg_d.home_end   = cfg_wdata_i;
        CFG_BS_DELETE:  cfg_d.bs_delete  = cfg_wdata_i[0];
        CFG_FN_STYLE:   cfg_d.fn_style   = fn_style_e'(cfg_wdata_i);
        CFG_APP_KEYPAD: cfg_d.app_keypad = cfg_wdata_i[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{app_cursor: 1'b0, home_end: 2'd0, bs_delete: 1'b0,
                 fn_style: FN_XTERM, app_keypad: 1'b0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Classify the key and build its byte sequence.
  logic [3:0] mp;
  logic       any_mod;
  logic [3:0] fn_num;
  seq_t       seq;

  assign mp      = 4'd1 + {3'b000, shift_held_i} + {2'b00, alt_held_i, 1'b0}
                 + {1'b0, ctrl_held_i, 2'b00};
  assign any_mod = shift_held_i | alt_held_i | ctrl_held_i;
  assign fn_num  = 4'(key_code_i - VkF1) + 4'd1;

  always_comb begin
    seq = '0;
    unique case (key_code_i)
      VkUp:       seq = seq_cursor(seq, 8'h41, mp, cfg_q.app_cursor);
      VkDown:     seq = seq_cursor(seq, 8'h42, mp, cfg_q.app_cursor);
      VkRight:    seq = seq_cursor(seq, 8'h43, mp, cfg_q.app_cursor);
      VkLeft:     seq = seq_cursor(seq, 8'h44, mp, cfg_q.app_cursor);
      VkHome: begin
        if (cfg_q.home_end == HOME_END_TILDE) begin
          seq = seq_tilde(seq, 5'd1, mp);
        end else if (cfg_q.home_end == HOME_END_RXVT) begin
          if (any_mod) begin
            seq = seq_cursor(seq, 8'h48, mp, 1'b0);
          end else begin
            seq = seq_put(seq, EscByte);
            seq = seq_put(seq, 8'h5B);
            seq = seq_put(seq, 8'h48);
          end
        end else begin
          seq = seq_cursor(seq, 8'h48, mp, cfg_q.app_cursor);
        end
      end
      VkEnd: begin
        if (cfg_q.home_end == HOME_END_TILDE) begin
          seq = seq_tilde(seq, 5'd4, mp);
        end else if (cfg_q.home_end == HOME_END_RXVT) begin
          if (any_mod) begin
            seq = seq_cursor(seq, 8'h46, mp, 1'b0);
          end else begin
            seq = seq_ss3(seq, 8'h77);
          end
        end else begin
          seq = seq_cursor(seq, 8'h46, mp, cfg_q.app_cursor);
        end
      end
      VkPageUp:   seq = seq_tilde(seq, 5'd5, mp);
      VkPageDown: seq = seq_tilde(seq, 5'd6, mp);
      VkInsert:   seq = seq_tilde(seq, 5'd2, mp);
      VkDelete:   seq = seq_tilde(seq, 5'd3, mp);
      VkBack: begin
        if (alt_held_i) begin
          seq = seq_put(seq, EscByte);
        end
        seq = seq_put(seq, (cfg_q.bs_delete != shift_held_i) ? DelByte : BsByte);
      end
      default: begin
        if (key_code_i >= VkF1 && key_code_i <= VkF12) begin
          seq = seq_fn(seq, cfg_q.fn_style, fn_num, mp, shift_held_i, ctrl_held_i);
        end else if (cfg_q.app_keypad && !ctrl_held_i && !alt_held_i) begin
          // Application keypad: digits map to SS3 p..y, operators to their own letter.
          if (key_code_i >= VkNum0 && key_code_i <= VkNum9) begin
            seq = seq_ss3(seq, key_code_i + 8'h10);
          end else if (key_code_i == VkDecimal) begin
            seq = seq_ss3(seq, 8'h6E);
          end else if (key_code_i == VkAdd) begin
            seq = seq_ss3(seq, 8'h6B);
          end else if (key_code_i == VkSubtract) begin
            seq = seq_ss3(seq, 8'h6D);
          end else if (key_code_i == VkMultiply) begin
            seq = seq_ss3(seq, 8'h6A);
          end else if (key_code_i == VkDivide) begin
            seq = seq_ss3(seq, 8'h6F);
          end
        end
      end
    endcase
  end

  assign seq_o = seq;

endmodule

`default_nettype wire

// ----- rtl/kesenc_queue.sv -----
`default_nettype none

module kesenc_queue import kesenc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire seq_t push_seq_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      head_valid_o,
  output seq_t      head_seq_o
);

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  seq_t            mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o       = (count_q == CntW'(QDepth));
  assign head_valid_o = (count_q != '0);
  assign head_seq_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset; entries are read only once written.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_seq_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/kesenc_back.sv -----
`default_nettype none
`include "key_to_escape_sequence_encoder_assert.svh"

module kesenc_back import kesenc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       head_valid_i,
  input  wire seq_t       head_seq_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            last_byte_o
);

  logic [2:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       last_q, last_d;
  logic       load;
  logic       is_last;

  // A new byte enters the output register whenever it is empty or being taken.
  assign load    = head_valid_i && (!out_valid_q || !out_stall_i);
  assign is_last = (idx_q == head_seq_i.len - 3'd1);
  assign pop_o   = load && is_last;

  always_comb begin
    idx_d       = idx_q;
    out_byte_d  = out_byte_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (load) begin
      out_byte_d  = head_seq_i.bytes[idx_q];
      last_d      = is_last;
      out_valid_d = 1'b1;
      idx_d       = is_last ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    last_q     <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_byte_o = last_q;

  // Only non-empty sequences are queued, and the byte index stays inside the head.
  `KESENC_ASSERT_IMPLIES(a_head_nonempty, head_valid_i, head_seq_i.len != 3'd0, "empty sequence")
  `KESENC_ASSERT_IMPLIES(a_idx_in_range, head_valid_i, idx_q < head_seq_i.len, "index past end")
  // A sequence leaves the queue exactly when its final byte is loaded.
  `KESENC_ASSERT_IMPLIES(a_pop_on_last, pop_o, load && is_last, "pop without final byte")
  `KESENC_ASSERT_ALWAYS(a_idx_zero_idle, head_valid_i || idx_q == 3'd0, "stale byte index")

endmodule

`default_nettype wire

// ----- rtl/key_to_escape_sequence_encoder.sv -----
`default_nettype none

// Key event to terminal byte sequence encoder. Each accepted key event (virtual-key
// code plus shift, alt and ctrl) is translated in the cycle it is accepted into a
// sequence of one to seven bytes, which waits in a two-entry queue and is then sent
// one byte per clock while out_stall_i is low, with last_byte_o marking its final
// byte; keys with no translation are accepted and produce nothing. Bytes leave
// through the single byte-wide output register; input is stalled only while the
// queue holds two sequences. Configuration registers are written by index through
// cfg_we_i and should change only while no sequence is in flight.

module key_to_escape_sequence_encoder import kesenc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_index_i,
  input  wire logic [1:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] key_code_i,
  input  wire logic       shift_held_i,
  input  wire logic       alt_held_i,
  input  wire logic       ctrl_held_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            last_byte_o
);

  seq_t front_seq;
  seq_t head_seq;
  logic q_full;
  logic head_valid;
  logic pop;
  logic push;

  // Front end: configuration and key classification.
  kesenc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .key_code_i   (key_code_i),
    .shift_held_i (shift_held_i),
    .alt_held_i   (alt_held_i),
    .ctrl_held_i  (ctrl_held_i),
    .seq_o        (front_seq)
  );

  // Untranslated keys are accepted but never queued.
  assign in_stall_o = q_full;
  assign push       = in_valid_i && (front_seq.len != 3'd0);

  kesenc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_seq_i   (front_seq),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_seq_o   (head_seq)
  );

  // Back end: byte serializer with output register.
  kesenc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_seq_i   (head_seq),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .last_byte_o  (last_byte_o)
  );

endmodule

`default_nettype wire
